// ----- rtl/aem_pkg.sv -----
`default_nettype none
package aem_pkg;

  localparam int DIR_BITS_DEF    = 16;
  localparam int MAX_MAP_DIM_DEF = 4096;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_PRESENT = 2'd2;

  localparam int OUT_W = 12;

  localparam int NORM_W    = 32;
  localparam int NORM_EXP  = 30;
  localparam int SH_W      = $clog2(NORM_W);
  localparam int SQ_W      = 2 * NORM_W;
  localparam int RHO_W     = 32;
  localparam int ISQ_REM_W = RHO_W + 2;

  localparam int TURN_BITS    = 24;
  localparam int HALF_TURN    = 1 << (TURN_BITS - 1);
  localparam int QUARTER_TURN = 1 << (TURN_BITS - 2);
  localparam int Q_W          = TURN_BITS + 1;
  localparam int OFF_W        = TURN_BITS;
  localparam int NUM_W        = NORM_W + OFF_W;

  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_W     = 36;
  localparam int ACC_W        = 26;

  localparam logic [ACC_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    26'd2097152, 26'd1238021, 26'd654136, 26'd332050, 26'd166669,
    26'd83416,   26'd41718,   26'd20860,  26'd10430,  26'd5215,
    26'd2608,    26'd1304,    26'd652,    26'd326,    26'd163,
    26'd81,      26'd41,      26'd20,     26'd10,     26'd5
  };

  typedef struct packed {
    logic [NORM_W-1:0] mx;
    logic [NORM_W-1:0] my;
    logic              nx;
    logic              ny;
    logic              pole;
  } lane_t;

  typedef struct packed {
    lane_t             lane;
    logic [NORM_W-1:0] mz;
    logic              nz;
  } root_side_t;

  typedef struct packed {
    lane_t            lane;
    logic [RHO_W-1:0] rho;
  } arc_side_t;

endpackage
`default_nettype wire

// ----- rtl/angular_env_map_texel_address.sv -----
// Angular light-probe texel address unit.
// Input stream: one ray direction per word on s_tdata (dir_x, dir_y, dir_z,
// two's complement, common scale). Output stream: texel row and column on
// m_tdata, use_background on m_tuser.
// Configuration: cfg_wr_en with cfg_index selects map_width (0), map_height (1)
// or map_present (2); write only while no words are in flight.
// The pipeline holds 4 normalize and square stages, 32 square-root stages
// (one root bit each), 20 CORDIC stages, one multiply stage, 24 divider
// stages (one quotient bit each for x and y), one map-scaling multiply stage
// and the output register. Throughput is one word per cycle unless the
// receiver stalls. The whole pipeline advances together
// whenever the output register is empty or being taken, so s_tready follows
// m_tready and a stalled receiver holds every stage in place.
// Reset clears all valid bits and returns the registers to 1024 x 1024 with
// no map present, so every word reports use_background.
`default_nettype none
module angular_env_map_texel_address #(
  parameter int MAX_MAP_DIM = aem_pkg::MAX_MAP_DIM_DEF,
  parameter int DIR_BITS    = aem_pkg::DIR_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // dir_x, dir_y, dir_z
  input  wire logic [((3*DIR_BITS+7)/8)*8-1:0] s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // texel_row, texel_col
  output logic [2*aem_pkg::OUT_W-1:0]          m_tdata,
  // use_background
  output logic                                 m_tuser,
  input  wire logic                            cfg_wr_en,
  input  wire logic [aem_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [aem_pkg::CFG_W-1:0]       cfg_data
);

  localparam int DIM_W  = $clog2(MAX_MAP_DIM + 1);
  localparam int PROD_W = aem_pkg::Q_W + DIM_W;

  logic                      en;
  logic [aem_pkg::CFG_W-1:0] map_width, map_height;
  logic                      map_present;
  logic [DIM_W-1:0]          w_eff, h_eff;

  logic                          n_valid;
  logic [aem_pkg::SQ_W-1:0]      n_sum;
  aem_pkg::root_side_t           n_side;
  logic                          r_valid;
  logic [aem_pkg::RHO_W-1:0]     r_rho;
  aem_pkg::root_side_t           r_side;
  logic                          c_valid;
  logic signed [aem_pkg::ACC_W-1:0] c_acc;
  aem_pkg::arc_side_t            c_side;

  logic [aem_pkg::OFF_W-1:0]     t;
  logic                          p_valid;
  logic [aem_pkg::NUM_W-1:0]     p_num [2];
  aem_pkg::arc_side_t            p_side;

  logic                          d_valid;
  logic [aem_pkg::OFF_W-1:0]     d_quo [2];
  aem_pkg::lane_t                d_side;

  logic [aem_pkg::Q_W-1:0]       uq, wq;
  logic                          f_valid;
  logic [PROD_W-1:0]             f_col, f_row;

  logic [DIM_W:0]                col_raw, row_raw;
  logic [DIM_W-1:0]              col_idx, row_idx;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [aem_pkg::CFG_W-1:0] d);
    if (d == '0) begin
      return DIM_W'(1);
    end
    if (32'(d) > MAX_MAP_DIM) begin
      return DIM_W'(MAX_MAP_DIM);
    end
    return DIM_W'(d);
  endfunction

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign w_eff    = eff_dim(map_width);
  assign h_eff    = eff_dim(map_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width   <= aem_pkg::CFG_W'(1024);
      map_height  <= aem_pkg::CFG_W'(1024);
      map_present <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        aem_pkg::REG_MAP_WIDTH:   map_width   <= cfg_data;
        aem_pkg::REG_MAP_HEIGHT:  map_height  <= cfg_data;
        aem_pkg::REG_MAP_PRESENT: map_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  aem_norm #(
    .DIR_BITS (DIR_BITS)
  ) u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .dir_x     (s_tdata[DIR_BITS-1:0]),
    .dir_y     (s_tdata[2*DIR_BITS-1:DIR_BITS]),
    .dir_z     (s_tdata[3*DIR_BITS-1:2*DIR_BITS]),
    .out_valid (n_valid),
    .out_sum   (n_sum),
    .out_side  (n_side)
  );

  aem_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (n_valid),
    .in_sum    (n_sum),
    .in_side   (n_side),
    .out_valid (r_valid),
    .out_rho   (r_rho),
    .out_side  (r_side)
  );

  aem_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r_valid),
    .in_rho    (r_rho),
    .in_side   (r_side),
    .out_valid (c_valid),
    .out_acc   (c_acc),
    .out_side  (c_side)
  );

  // angle clamped to [0, half turn]
  always_comb begin
    if (c_acc < 0) begin
      t = '0;
    end else if (c_acc > $signed(aem_pkg::ACC_W'(aem_pkg::HALF_TURN))) begin
      t = aem_pkg::OFF_W'(aem_pkg::HALF_TURN);
    end else begin
      t = c_acc[aem_pkg::OFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_num[0] <= aem_pkg::NUM_W'(c_side.lane.mx) * aem_pkg::NUM_W'(t);
      p_num[1] <= aem_pkg::NUM_W'(c_side.lane.my) * aem_pkg::NUM_W'(t);
      p_side   <= c_side;
    end
  end

  aem_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_valid),
    .in_num    (p_num),
    .in_den    (p_side.rho),
    .in_side   (p_side.lane),
    .out_valid (d_valid),
    .out_quo   (d_quo),
    .out_side  (d_side)
  );

  // map coordinates in turns; the pole and the zero vector land on the centre
  always_comb begin
    if (d_side.pole || d_side.mx == '0 && d_side.my == '0) begin
      uq = aem_pkg::Q_W'(aem_pkg::HALF_TURN);
      wq = aem_pkg::Q_W'(aem_pkg::HALF_TURN);
    end else begin
      uq = d_side.nx ? aem_pkg::Q_W'(aem_pkg::HALF_TURN) - aem_pkg::Q_W'(d_quo[0])
                     : aem_pkg::Q_W'(aem_pkg::HALF_TURN) + aem_pkg::Q_W'(d_quo[0]);
      wq = d_side.ny ? aem_pkg::Q_W'(aem_pkg::HALF_TURN) + aem_pkg::Q_W'(d_quo[1])
                     : aem_pkg::Q_W'(aem_pkg::HALF_TURN) - aem_pkg::Q_W'(d_quo[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_col <= PROD_W'(uq) * PROD_W'(w_eff);
      f_row <= PROD_W'(wq) * PROD_W'(h_eff);
    end
  end

  // saturate at the map edge
  always_comb begin
    col_raw = f_col[PROD_W-1:aem_pkg::TURN_BITS];
    row_raw = f_row[PROD_W-1:aem_pkg::TURN_BITS];
    col_idx = (col_raw > {1'b0, w_eff - DIM_W'(1)}) ? w_eff - DIM_W'(1) : col_raw[DIM_W-1:0];
    row_idx = (row_raw > {1'b0, h_eff - DIM_W'(1)}) ? h_eff - DIM_W'(1) : row_raw[DIM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (map_present) begin
        m_tdata <= {aem_pkg::OUT_W'(col_idx), aem_pkg::OUT_W'(row_idx)};
        m_tuser <= 1'b0;
      end else begin
        m_tdata <= '0;
        m_tuser <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/aem_norm.sv -----
`default_nettype none
module aem_norm #(
  parameter int DIR_BITS = aem_pkg::DIR_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [DIR_BITS-1:0]       dir_x,
  input  wire logic [DIR_BITS-1:0]       dir_y,
  input  wire logic [DIR_BITS-1:0]       dir_z,
  output logic                           out_valid,
  output logic [aem_pkg::SQ_W-1:0]       out_sum,
  output aem_pkg::root_side_t            out_side
);

  logic [DIR_BITS-1:0] magx, magy, magz, magm;
  logic                v1;
  logic [DIR_BITS-1:0] mx1, my1, mz1, m1;
  logic                nx1, ny1, nz1;

  logic [aem_pkg::NORM_W-1:0] m32;
  logic [aem_pkg::SH_W-1:0]   msb, sh;
  logic                       v2;
  logic [aem_pkg::NORM_W-1:0] mx2, my2, mz2;
  logic                       nx2, ny2, nz2, pole2;

  logic                       v3;
  logic [aem_pkg::SQ_W-1:0]   sqx3, sqy3;
  logic [aem_pkg::NORM_W-1:0] mx3, my3, mz3;
  logic                       nx3, ny3, nz3, pole3;

  // magnitudes; the most negative code maps onto its own bit pattern
  always_comb begin
    magx = dir_x[DIR_BITS-1] ? (~dir_x + DIR_BITS'(1)) : dir_x;
    magy = dir_y[DIR_BITS-1] ? (~dir_y + DIR_BITS'(1)) : dir_y;
    magz = dir_z[DIR_BITS-1] ? (~dir_z + DIR_BITS'(1)) : dir_z;
    magm = magx;
    if (magy > magm) begin
      magm = magy;
    end
    if (magz > magm) begin
      magm = magz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx1 <= magx;
      my1 <= magy;
      mz1 <= magz;
      m1  <= magm;
      nx1 <= dir_x[DIR_BITS-1];
      ny1 <= dir_y[DIR_BITS-1];
      nz1 <= dir_z[DIR_BITS-1];
    end
  end

  // shift so the largest magnitude reaches the normalization floor
  always_comb begin
    m32 = aem_pkg::NORM_W'(m1);
    msb = '0;
    for (int i = 0; i < aem_pkg::NORM_W; i++) begin
      if (m32[i]) begin
        msb = aem_pkg::SH_W'(i);
      end
    end
    if (m32[aem_pkg::NORM_W-1] || m32[aem_pkg::NORM_EXP]) begin
      sh = '0;
    end else begin
      sh = aem_pkg::SH_W'(aem_pkg::NORM_EXP) - msb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx2   <= aem_pkg::NORM_W'(mx1) << sh;
      my2   <= aem_pkg::NORM_W'(my1) << sh;
      mz2   <= aem_pkg::NORM_W'(mz1) << sh;
      nx2   <= nx1;
      ny2   <= ny1;
      nz2   <= nz1;
      pole2 <= (m1 == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx3  <= aem_pkg::SQ_W'(mx2) * aem_pkg::SQ_W'(mx2);
      sqy3  <= aem_pkg::SQ_W'(my2) * aem_pkg::SQ_W'(my2);
      mx3   <= mx2;
      my3   <= my2;
      mz3   <= mz2;
      nx3   <= nx2;
      ny3   <= ny2;
      nz3   <= nz2;
      pole3 <= pole2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sum            <= sqx3 + sqy3;
      out_side.lane.mx   <= mx3;
      out_side.lane.my   <= my3;
      out_side.lane.nx   <= nx3;
      out_side.lane.ny   <= ny3;
      out_side.lane.pole <= pole3;
      out_side.mz        <= mz3;
      out_side.nz        <= nz3;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/aem_isqrt.sv -----
`default_nettype none
module aem_isqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [aem_pkg::SQ_W-1:0]    in_sum,
  input  wire aem_pkg::root_side_t         in_side,
  output logic                             out_valid,
  output logic [aem_pkg::RHO_W-1:0]        out_rho,
  output aem_pkg::root_side_t              out_side
);

  localparam int STEPS = aem_pkg::RHO_W;

  logic [aem_pkg::SQ_W-1:0]      rad_q  [STEPS];
  logic [aem_pkg::ISQ_REM_W-1:0] rem_q  [STEPS];
  logic [aem_pkg::RHO_W-1:0]     root_q [STEPS];
  logic                          v_q    [STEPS];
  aem_pkg::root_side_t           side_q [STEPS];

  // one result bit per stage
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [aem_pkg::SQ_W-1:0]      rad_i;
    logic [aem_pkg::ISQ_REM_W-1:0] rem_i;
    logic [aem_pkg::RHO_W-1:0]     root_i;
    logic                          v_i;
    aem_pkg::root_side_t           side_i;
    logic [aem_pkg::ISQ_REM_W+1:0] cur, trial;
    logic                          fit;

    if (k == 0) begin : g_head
      assign rad_i  = in_sum;
      assign rem_i  = '0;
      assign root_i = '0;
      assign v_i    = in_valid;
      assign side_i = in_side;
    end else begin : g_tail
      assign rad_i  = rad_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign v_i    = v_q[k-1];
      assign side_i = side_q[k-1];
    end

    assign cur   = {rem_i, rad_i[aem_pkg::SQ_W-1 -: 2]};
    assign trial = (aem_pkg::ISQ_REM_W + 2)'({root_i, 2'b01});
    assign fit   = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k]  <= rad_i << 2;
        rem_q[k]  <= fit ? aem_pkg::ISQ_REM_W'(cur - trial) : aem_pkg::ISQ_REM_W'(cur);
        root_q[k] <= {root_i[aem_pkg::RHO_W-2:0], fit};
        side_q[k] <= side_i;
      end
    end
  end

  assign out_valid = v_q[STEPS-1];
  assign out_rho   = root_q[STEPS-1];
  assign out_side  = side_q[STEPS-1];

endmodule
`default_nettype wire

// ----- rtl/aem_cordic.sv -----
`default_nettype none
module aem_cordic (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             en,
  input  wire logic                             in_valid,
  input  wire logic [aem_pkg::RHO_W-1:0]        in_rho,
  input  wire aem_pkg::root_side_t              in_side,
  output logic                                  out_valid,
  output logic signed [aem_pkg::ACC_W-1:0]      out_acc,
  output aem_pkg::arc_side_t                    out_side
);

  localparam int STEPS = aem_pkg::CORDIC_STEPS;

  logic signed [aem_pkg::CORDIC_W-1:0] cx_q  [STEPS];
  logic signed [aem_pkg::CORDIC_W-1:0] cy_q  [STEPS];
  logic signed [aem_pkg::ACC_W-1:0]    acc_q [STEPS];
  logic                                v_q   [STEPS];
  aem_pkg::arc_side_t                  side_q[STEPS];

  // vectoring mode on (z, rho), pre-rotated a quarter turn for z < 0
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic signed [aem_pkg::CORDIC_W-1:0] cx_i, cy_i, dx, dy;
    logic signed [aem_pkg::ACC_W-1:0]    acc_i;
    logic                                v_i;
    aem_pkg::arc_side_t                  side_i;

    if (k == 0) begin : g_head
      assign cx_i  = in_side.nz ? aem_pkg::CORDIC_W'(in_rho) : aem_pkg::CORDIC_W'(in_side.mz);
      assign cy_i  = in_side.nz ? aem_pkg::CORDIC_W'(in_side.mz) : aem_pkg::CORDIC_W'(in_rho);
      assign acc_i = in_side.nz ? aem_pkg::ACC_W'(aem_pkg::QUARTER_TURN) : '0;
      assign v_i   = in_valid;
      assign side_i.lane = in_side.lane;
      assign side_i.rho  = in_rho;
    end else begin : g_tail
      assign cx_i   = cx_q[k-1];
      assign cy_i   = cy_q[k-1];
      assign acc_i  = acc_q[k-1];
      assign v_i    = v_q[k-1];
      assign side_i = side_q[k-1];
    end

    assign dx = cy_i >>> k;
    assign dy = cx_i >>> k;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (cy_i > 0) begin
          cx_q[k]  <= cx_i + dx;
          cy_q[k]  <= cy_i - dy;
          acc_q[k] <= acc_i + $signed(aem_pkg::ATAN_TURNS[k]);
        end else begin
          cx_q[k]  <= cx_i - dx;
          cy_q[k]  <= cy_i + dy;
          acc_q[k] <= acc_i - $signed(aem_pkg::ATAN_TURNS[k]);
        end
        side_q[k] <= side_i;
      end
    end
  end

  assign out_valid = v_q[STEPS-1];
  assign out_acc   = acc_q[STEPS-1];
  assign out_side  = side_q[STEPS-1];

endmodule
`default_nettype wire

// ----- rtl/aem_divide.sv -----
`default_nettype none
module aem_divide (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [aem_pkg::NUM_W-1:0]   in_num [2],
  input  wire logic [aem_pkg::RHO_W-1:0]   in_den,
  input  wire aem_pkg::lane_t              in_side,
  output logic                             out_valid,
  output logic [aem_pkg::OFF_W-1:0]        out_quo [2],
  output aem_pkg::lane_t                   out_side
);

  localparam int STEPS = aem_pkg::OFF_W;

  logic [aem_pkg::RHO_W-1:0] rem_q [STEPS][2];
  logic [aem_pkg::OFF_W-1:0] low_q [STEPS][2];
  logic [aem_pkg::OFF_W-1:0] quo_q [STEPS][2];
  logic [aem_pkg::RHO_W-1:0] den_q [STEPS];
  logic                      v_q   [STEPS];
  aem_pkg::lane_t            side_q[STEPS];

  // restoring division, one quotient bit per stage, x and y side by side
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [aem_pkg::RHO_W-1:0] den_i;
    logic                      v_i;
    aem_pkg::lane_t            side_i;

    if (k == 0) begin : g_head
      assign den_i  = in_den;
      assign v_i    = in_valid;
      assign side_i = in_side;
    end else begin : g_tail
      assign den_i  = den_q[k-1];
      assign v_i    = v_q[k-1];
      assign side_i = side_q[k-1];
    end

    for (genvar j = 0; j < 2; j++) begin : g_lane
      logic [aem_pkg::RHO_W-1:0] rem_i;
      logic [aem_pkg::OFF_W-1:0] low_i, quo_i;
      logic [aem_pkg::RHO_W:0]   cur;
      logic                      fit;

      if (k == 0) begin : g_head
        assign rem_i = in_num[j][aem_pkg::NUM_W-1:aem_pkg::OFF_W];
        assign low_i = in_num[j][aem_pkg::OFF_W-1:0];
        assign quo_i = '0;
      end else begin : g_tail
        assign rem_i = rem_q[k-1][j];
        assign low_i = low_q[k-1][j];
        assign quo_i = quo_q[k-1][j];
      end

      assign cur = {rem_i, low_i[aem_pkg::OFF_W-1]};
      assign fit = (cur >= {1'b0, den_i});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k][j] <= fit ? aem_pkg::RHO_W'(cur - {1'b0, den_i}) : aem_pkg::RHO_W'(cur);
          low_q[k][j] <= low_i << 1;
          quo_q[k][j] <= {quo_i[aem_pkg::OFF_W-2:0], fit};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[k]  <= den_i;
        side_q[k] <= side_i;
      end
    end
  end

  assign out_valid  = v_q[STEPS-1];
  assign out_quo[0] = quo_q[STEPS-1][0];
  assign out_quo[1] = quo_q[STEPS-1][1];
  assign out_side   = side_q[STEPS-1];

endmodule
`default_nettype wire
